// ----- rtl/dhfk_pkg.sv -----
// dhfk_pkg: shared types, widths and constants of the dh forward kinematics chain
// no dependencies; imported by every module of the block
`default_nettype none
package dhfk_pkg;

   // chain length and joint counter
   localparam int JOINTS       = 6;
   localparam int JCW          = 3;

   // field widths
   localparam int ANG_W        = 15;
   localparam int LEN_W        = 32;
   localparam int ROT_W        = 32;

   // cordic datapath
   localparam int CORDIC_STEPS = 30;
   localparam int STEP_W       = 5;
   localparam int CW           = 34;
   localparam int ZW           = 35;

   localparam logic signed [ZW-1:0]    PI_Q30      = 35'sd3373259426;
   localparam logic signed [ZW-1:0]    HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [CW-1:0]    CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [ROT_W-1:0] ONE_Q30     = 32'sd1073741824;

   // one joint row
   typedef struct packed {
      logic signed [ANG_W-1:0] theta;
      logic signed [ANG_W-1:0] alpha;
      logic signed [LEN_W-1:0] link_length;
      logic signed [LEN_W-1:0] link_offset;
   } item_type;

   // arctangent of 2^-i in q30 radians
   function automatic logic signed [ZW-1:0] atan_q30(input logic [STEP_W-1:0] i);
      logic signed [ZW-1:0] v;
      case (i)
         5'd0:  v = 35'sh03243F6A8;
         5'd1:  v = 35'sh01DAC6705;
         5'd2:  v = 35'sh00FADBAFC;
         5'd3:  v = 35'sh007F56EA6;
         5'd4:  v = 35'sh003FEAB76;
         5'd5:  v = 35'sh001FFD55B;
         5'd6:  v = 35'sh000FFFAAA;
         5'd7:  v = 35'sh0007FFF55;
         5'd8:  v = 35'sh0003FFFEA;
         5'd9:  v = 35'sh0001FFFFD;
         5'd10: v = 35'sh0000FFFFF;
         5'd11: v = 35'sh00007FFFF;
         5'd12: v = 35'sh00003FFFF;
         5'd13: v = 35'sh00001FFFF;
         5'd14: v = 35'sh00000FFFF;
         5'd15: v = 35'sh000007FFF;
         5'd16: v = 35'sh000003FFF;
         5'd17: v = 35'sh000001FFF;
         5'd18: v = 35'sh000000FFF;
         5'd19: v = 35'sh0000007FF;
         5'd20: v = 35'sh0000003FF;
         5'd21: v = 35'sh0000001FF;
         5'd22: v = 35'sh0000000FF;
         5'd23: v = 35'sh00000007F;
         5'd24: v = 35'sh00000003F;
         5'd25: v = 35'sh00000001F;
         5'd26: v = 35'sh00000000F;
         5'd27: v = 35'sh000000008;
         5'd28: v = 35'sh000000004;
         5'd29: v = 35'sh000000002;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/dh_forward_kinematics_chain.sv -----
// channel  | direction | ports
// req      | in        | req_valid/req_ready, theta, alpha, link_length, link_offset
// rsp      | out       | rsp_valid/rsp_ready, row_index, rot_col0..2, position, last_row
//
// in the back end each joint row passes through a launch from idle, the 30 cordic steps
// (theta and alpha in parallel) and the done check, 6 transform products and 36 matrix
// products through one shared 32x32 multiplier, then a drain and a commit state; the
// cordic steps and the multiplier products make up the bulk of each row's work
// the front queue holds two rows, so req_ready drops only once two rows wait behind
// the one in the back end
// after the last joint three pose rows leave, one per rsp transaction, each held while
// rsp_ready is low
// reset is synchronous: pose returns to identity and zero, queue empties
// top level: dh forward kinematics chain; depends on dhfk_pkg, dhfk_front, dhfk_back
`default_nettype none
module dh_forward_kinematics_chain (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic signed [14:0]  req_theta,
   input  wire logic signed [14:0]  req_alpha,
   input  wire logic signed [31:0]  req_link_length,
   input  wire logic signed [31:0]  req_link_offset,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [1:0]               rsp_row_index,
   output logic signed [31:0]       rsp_rot_col0,
   output logic signed [31:0]       rsp_rot_col1,
   output logic signed [31:0]       rsp_rot_col2,
   output logic signed [31:0]       rsp_position,
   output logic                     rsp_last_row
);
   import dhfk_pkg::*;

   logic     item_valid, item_ready;
   item_type item;

   // accepting front end
   dhfk_front u_front (
      .clock (clock), .reset (reset),
      .req_valid (req_valid), .req_ready (req_ready),
      .req_theta (req_theta), .req_alpha (req_alpha),
      .req_link_length (req_link_length), .req_link_offset (req_link_offset),
      .item_valid (item_valid), .item_ready (item_ready), .item (item)
   );

   // compute back end
   dhfk_back u_back (
      .clock (clock), .reset (reset),
      .item_valid (item_valid), .item_ready (item_ready), .item (item),
      .rsp_valid (rsp_valid), .rsp_ready (rsp_ready),
      .rsp_row_index (rsp_row_index), .rsp_rot_col0 (rsp_rot_col0),
      .rsp_rot_col1 (rsp_rot_col1), .rsp_rot_col2 (rsp_rot_col2),
      .rsp_position (rsp_position), .rsp_last_row (rsp_last_row)
   );

endmodule
`default_nettype wire

// ----- rtl/dhfk_front.sv -----
// dhfk_front: two-entry queue that accepts joint rows ahead of the back end
// depends on dhfk_pkg
`default_nettype none
module dhfk_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [14:0]         req_theta,
   input  wire logic signed [14:0]         req_alpha,
   input  wire logic signed [31:0]         req_link_length,
   input  wire logic signed [31:0]         req_link_offset,
   output logic                            item_valid,
   input  wire logic                       item_ready,
   output dhfk_pkg::item_type              item
);
   import dhfk_pkg::*;

   item_type   mem_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   // handshake on both sides
   assign req_ready  = (cnt_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign item_valid = (cnt_ff != 2'd0);
   assign pop        = item_valid && item_ready;
   assign item       = mem_ff[rptr_ff];

   // pointer and count update
   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= '{theta: req_theta, alpha: req_alpha,
                              link_length: req_link_length,
                              link_offset: req_link_offset};
      end
   end

endmodule
`default_nettype wire

// ----- rtl/dhfk_cordic.sv -----
// dhfk_cordic: iterative sine and cosine, one rotation step per cycle
// depends on dhfk_pkg (atan table, widths, gain)
`default_nettype none
module dhfk_cordic (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic signed [14:0]         angle,
   output logic                            done,
   output logic signed [31:0]              sin_q,
   output logic signed [31:0]              cos_q
);
   import dhfk_pkg::*;

   logic signed [CW-1:0]   x_ff, x_in, y_ff, y_in, xs, ys, xo, yo;
   logic signed [ZW-1:0]   z_ff, z_in, ang_w, z0;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   run_ff, run_in, done_ff, done_in, neg_ff, neg_in;

   localparam logic signed [CW-1:0] ONE_W = CW'(ONE_Q30);

   // widen to q30 radians and fold into plus or minus half pi
   assign ang_w = {{(ZW-ANG_W-18){angle[ANG_W-1]}}, angle, 18'b0};
   assign xs    = x_ff >>> step_ff;
   assign ys    = y_ff >>> step_ff;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = done_ff;
      neg_in  = neg_ff;
      z0      = ang_w;
      if (start) begin
         neg_in = 1'b0;
         if (ang_w > HALF_PI_Q30) begin
            z0     = ang_w - PI_Q30;
            neg_in = 1'b1;
         end else if (ang_w < -HALF_PI_Q30) begin
            z0     = ang_w + PI_Q30;
            neg_in = 1'b1;
         end
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = z0;
         step_in = '0;
         run_in  = 1'b1;
         done_in = 1'b0;
      end else if (run_ff) begin
         // one rotation toward zero residual angle
         if (!z_ff[ZW-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_q30(step_ff);
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_q30(step_ff);
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
   end

   // sign fix and clamp to plus or minus one
   always_comb begin
      xo = neg_ff ? -x_ff : x_ff;
      yo = neg_ff ? -y_ff : y_ff;
      if (xo > ONE_W) begin
         xo = ONE_W;
      end else if (xo < -ONE_W) begin
         xo = -ONE_W;
      end
      if (yo > ONE_W) begin
         yo = ONE_W;
      end else if (yo < -ONE_W) begin
         yo = -ONE_W;
      end
   end

   assign cos_q = ROT_W'(xo);
   assign sin_q = ROT_W'(yo);
   assign done  = done_ff;

endmodule
`default_nettype wire

// ----- rtl/dhfk_back.sv -----
// dhfk_back: joint transform build, shared multiplier and pose accumulation
// depends on dhfk_pkg and dhfk_cordic
`default_nettype none
module dhfk_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       item_valid,
   output logic                            item_ready,
   input  wire dhfk_pkg::item_type         item,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [1:0]                      rsp_row_index,
   output logic signed [31:0]              rsp_rot_col0,
   output logic signed [31:0]              rsp_rot_col1,
   output logic signed [31:0]              rsp_rot_col2,
   output logic signed [31:0]              rsp_position,
   output logic                            rsp_last_row
);
   import dhfk_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_CORDIC = 7'b0000010,
      S_TPROD  = 7'b0000100,
      S_MPROD  = 7'b0001000,
      S_DRAIN  = 7'b0010000,
      S_COMMIT = 7'b0100000,
      S_EMIT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [ROT_W-1:0] rot_ff [9];
   logic signed [ROT_W-1:0] nr_ff  [9];
   logic signed [ROT_W-1:0] tj_ff  [9];
   logic signed [LEN_W-1:0] pos_ff [3];
   logic signed [LEN_W-1:0] np_ff  [3];
   logic signed [LEN_W-1:0] pj_ff  [3];
   logic signed [LEN_W-1:0] la_ff;

   logic [JCW-1:0] jc_ff;
   logic [1:0]     row_ff;
   logic [2:0]     t_ff;
   logic [1:0]     r_ff, c_ff, k_ff;

   // product stage tags
   logic                pv_ff, pt_ff;
   logic [2:0]          ptt_ff;
   logic [1:0]          pr_ff, pc_ff, pk_ff;
   logic signed [63:0]  prod_ff;
   logic signed [65:0]  acc_ff, sum, rsum;
   logic signed [35:0]  rnd;
   logic signed [36:0]  psum;

   logic                         cstart, st_done, sa_done;
   logic signed [ROT_W-1:0]      st, ct, sa, ca;
   logic signed [31:0]           op_a, op_b;
   logic signed [63:0]           mult;
   logic [3:0]                   ridx, tidx;

   dhfk_cordic u_theta (
      .clock (clock), .reset (reset), .start (cstart), .angle (item.theta),
      .done  (st_done), .sin_q (st), .cos_q (ct)
   );

   dhfk_cordic u_alpha (
      .clock (clock), .reset (reset), .start (cstart), .angle (item.alpha),
      .done  (sa_done), .sin_q (sa), .cos_q (ca)
   );

   function automatic logic signed [ROT_W-1:0] clamp_one(input logic signed [35:0] v);
      logic signed [35:0] lim;
      lim = 36'(ONE_Q30);
      if (v > lim) return ONE_Q30;
      if (v < -lim) return -ONE_Q30;
      return ROT_W'(v);
   endfunction

   function automatic logic signed [LEN_W-1:0] sat32(input logic signed [36:0] v);
      if (v > 37'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -37'sd2147483648) return 32'sh80000000;
      return LEN_W'(v);
   endfunction

   // item pop and cordic launch
   assign item_ready = (state_ff == S_IDLE);
   assign cstart     = item_valid && item_ready;

   // operand selection for the shared multiplier
   assign ridx = 4'(r_ff) * 4'd3 + 4'(k_ff);
   assign tidx = 4'(k_ff) * 4'd3 + 4'(c_ff);
   always_comb begin
      op_a = rot_ff[ridx];
      op_b = (c_ff == 2'd3) ? pj_ff[k_ff] : tj_ff[tidx];
      if (state_ff == S_TPROD) begin
         case (t_ff)
            3'd0: begin op_a = -st;   op_b = ca; end
            3'd1: begin op_a = st;    op_b = sa; end
            3'd2: begin op_a = ct;    op_b = ca; end
            3'd3: begin op_a = -ct;   op_b = sa; end
            3'd4: begin op_a = la_ff; op_b = ct; end
            3'd5: begin op_a = la_ff; op_b = st; end
            default: begin op_a = '0; op_b = '0; end
         endcase
      end
   end
   assign mult = op_a * op_b;

   // accumulate, round to q30 and add the old position
   always_comb begin
      sum  = (pt_ff || pk_ff == 2'd0) ? 66'(prod_ff) : acc_ff + 66'(prod_ff);
      rsum = sum + 66'sd536870912;
      rnd  = rsum[65:30];
      psum = 37'(rnd) + 37'(pos_ff[pr_ff]);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (cstart) state_in = S_CORDIC;
         S_CORDIC: if (st_done && sa_done) state_in = S_TPROD;
         S_TPROD:  if (t_ff == 3'd5) state_in = S_MPROD;
         S_MPROD:  if (r_ff == 2'd2 && c_ff == 2'd3 && k_ff == 2'd2) state_in = S_DRAIN;
         S_DRAIN:  state_in = S_COMMIT;
         S_COMMIT: state_in = (jc_ff == JCW'(JOINTS - 1)) ? S_EMIT : S_IDLE;
         S_EMIT:   if (rsp_ready && row_ff == 2'd2) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         jc_ff    <= '0;
         row_ff   <= 2'd0;
         pv_ff    <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            rot_ff[i] <= (i % 4 == 0) ? ONE_Q30 : '0;
         end
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         pv_ff    <= (state_ff == S_TPROD) || (state_ff == S_MPROD);
         if (state_ff == S_COMMIT) begin
            rot_ff <= nr_ff;
            pos_ff <= np_ff;
            jc_ff  <= (jc_ff == JCW'(JOINTS - 1)) ? '0 : jc_ff + 1'b1;
            row_ff <= 2'd0;
         end
         if (state_ff == S_EMIT && rsp_ready) begin
            row_ff <= row_ff + 2'd1;
            // rows move up so row zero always faces the output
            if (row_ff == 2'd2) begin
               for (int i = 0; i < 9; i++) begin
                  rot_ff[i] <= (i % 4 == 0) ? ONE_Q30 : '0;
               end
               for (int i = 0; i < 3; i++) begin
                  pos_ff[i] <= '0;
               end
            end else begin
               for (int i = 0; i < 6; i++) begin
                  rot_ff[i] <= rot_ff[i+3];
               end
               pos_ff[0] <= pos_ff[1];
               pos_ff[1] <= pos_ff[2];
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (cstart) begin
         la_ff    <= item.link_length;
         pj_ff[2] <= item.link_offset;
      end
      if (state_ff == S_CORDIC) begin
         tj_ff[0] <= ct;
         tj_ff[3] <= st;
         tj_ff[6] <= '0;
         tj_ff[7] <= sa;
         tj_ff[8] <= ca;
         t_ff     <= 3'd0;
         r_ff     <= 2'd0;
         c_ff     <= 2'd0;
         k_ff     <= 2'd0;
      end
      if (state_ff == S_TPROD) begin
         t_ff <= t_ff + 3'd1;
      end
      if (state_ff == S_MPROD) begin
         k_ff <= (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
         if (k_ff == 2'd2) begin
            c_ff <= c_ff + 2'd1;
            if (c_ff == 2'd3) begin
               r_ff <= r_ff + 2'd1;
            end
         end
      end
      // product register with its destination tag
      prod_ff <= mult;
      pt_ff   <= (state_ff == S_TPROD);
      ptt_ff  <= t_ff;
      pr_ff   <= r_ff;
      pc_ff   <= c_ff;
      pk_ff   <= k_ff;
      acc_ff  <= sum;
      // result write-back
      if (pv_ff && pt_ff) begin
         case (ptt_ff)
            3'd0:    tj_ff[1] <= clamp_one(rnd);
            3'd1:    tj_ff[2] <= clamp_one(rnd);
            3'd2:    tj_ff[4] <= clamp_one(rnd);
            3'd3:    tj_ff[5] <= clamp_one(rnd);
            3'd4:    pj_ff[0] <= sat32(37'(rnd));
            3'd5:    pj_ff[1] <= sat32(37'(rnd));
            default: ;
         endcase
      end
      if (pv_ff && !pt_ff && pk_ff == 2'd2) begin
         if (pc_ff == 2'd3) begin
            np_ff[pr_ff] <= sat32(psum);
         end else begin
            nr_ff[4'(pr_ff) * 4'd3 + 4'(pc_ff)] <= clamp_one(rnd);
         end
      end
   end

   // result port
   assign rsp_valid     = (state_ff == S_EMIT);
   assign rsp_row_index = row_ff;
   assign rsp_rot_col0  = rot_ff[0];
   assign rsp_rot_col1  = rot_ff[1];
   assign rsp_rot_col2  = rot_ff[2];
   assign rsp_position  = pos_ff[0];
   assign rsp_last_row  = (row_ff == 2'd2);

   a_jc_range: assert property (@(posedge clock) disable iff (reset)
      jc_ff < JCW'(JOINTS)) else $error("joint counter out of range");

   a_cordic_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TPROD |-> st_done && sa_done)
      else $error("products started before sine and cosine were done");

   a_pose_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_row |=>
         rot_ff[0] == ONE_Q30 && rot_ff[4] == ONE_Q30 && pos_ff[0] == '0)
      else $error("pose not restarted after the last row");

   a_rot_range: assert property (@(posedge clock) disable iff (reset)
      rot_ff[0] <= ONE_Q30 && rot_ff[0] >= -ONE_Q30)
      else $error("rotation entry out of range");

endmodule
`default_nettype wire

// ----- test/dh_forward_kinematics_chain_test.sv -----
// testbench for dh_forward_kinematics_chain: joint rows in, pose rows out, checked
// against an in-bench fixed-point kinematics predictor; depends on dhfk_pkg and the rtl
`default_nettype none
module dh_forward_kinematics_chain_test;
   import dhfk_pkg::*;

   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [31:0] rot_col0;
      logic signed [31:0] rot_col1;
      logic signed [31:0] rot_col2;
      logic signed [31:0] position;
      logic               last_row;
   } pose_row_type;

   typedef struct {
      logic signed [14:0] theta;
      logic signed [14:0] alpha;
      logic signed [31:0] link_length;
      logic signed [31:0] link_offset;
   } joint_row_type;

   localparam longint UNIT = 64'sd1073741824;
   localparam longint HALF = 64'sd536870912;
   localparam longint PI_V = 64'sd3373259426;
   localparam longint HPI_V = 64'sd1686629713;
   localparam longint GAIN = 64'sd652032874;
   localparam longint I32_MIN = -64'sd2147483648;
   localparam longint I32_MAX = 64'sd2147483647;
   localparam int LIMIT = 400000;
   localparam int DIRECTED = 13;
   localparam int RANDOM_ITEMS = 155;
   localparam int QUIET_TAIL = 30;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [14:0] req_theta = '0;
   logic signed [14:0] req_alpha = '0;
   logic signed [31:0] req_link_length = '0;
   logic signed [31:0] req_link_offset = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_row_index;
   logic signed [31:0] rsp_rot_col0, rsp_rot_col1, rsp_rot_col2, rsp_position;
   logic rsp_last_row;

   dh_forward_kinematics_chain dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_theta(req_theta), .req_alpha(req_alpha),
      .req_link_length(req_link_length), .req_link_offset(req_link_offset),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_row_index(rsp_row_index), .rsp_rot_col0(rsp_rot_col0),
      .rsp_rot_col1(rsp_rot_col1), .rsp_rot_col2(rsp_rot_col2),
      .rsp_position(rsp_position), .rsp_last_row(rsp_last_row)
   );

   always #1 clock = ~clock;

   // predictor state: pose so far and joint count
   longint pose_rot [9];
   longint pose_pos [3];
   int joints_done;
   pose_row_type pending_rows [$];
   int mismatches = 0;
   int cycles = 0;
   int rows_seen = 0;
   int stall_left = 0;
   bit rsp_quiet = 1'b0;

   function automatic longint shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint rnd30(longint v);
      return (v + HALF) >>> 30;
   endfunction

   function automatic longint atan_step(int i);
      case (i)
         0: return 64'h3243F6A8;   1: return 64'h1DAC6705;   2: return 64'h0FADBAFC;
         3: return 64'h07F56EA6;   4: return 64'h03FEAB76;   5: return 64'h01FFD55B;
         6: return 64'h00FFFAAA;   7: return 64'h007FFF55;   8: return 64'h003FFFEA;
         9: return 64'h001FFFFD;   10: return 64'h000FFFFF;  11: return 64'h0007FFFF;
         12: return 64'h0003FFFF;  13: return 64'h0001FFFF;  14: return 64'h0000FFFF;
         15: return 64'h00007FFF;  16: return 64'h00003FFF;  17: return 64'h00001FFF;
         18: return 64'h00000FFF;  19: return 64'h000007FF;  20: return 64'h000003FF;
         21: return 64'h000001FF;  22: return 64'h000000FF;  23: return 64'h0000007F;
         24: return 64'h0000003F;  25: return 64'h0000001F;  26: return 64'h0000000F;
         27: return 64'h00000008;  28: return 64'h00000004;  default: return 64'h2;
      endcase
   endfunction

   // cordic sine and cosine of a q3.12 angle, q2.30 results
   task automatic angle_sincos(input logic signed [14:0] ang, output longint s,
                               output longint c);
      longint z, x, y, nx;
      bit flip;
      z = longint'(ang) * 262144;
      x = GAIN;
      y = 0;
      flip = 1'b0;
      if (z > HPI_V) begin
         z -= PI_V; flip = 1'b1;
      end else if (z < -HPI_V) begin
         z += PI_V; flip = 1'b1;
      end
      for (int i = 0; i < 30; i++) begin
         if (z >= 0) begin
            nx = x - shr(y, i); y = y + shr(x, i); z -= atan_step(i);
         end else begin
            nx = x + shr(y, i); y = y - shr(x, i); z += atan_step(i);
         end
         x = nx;
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = clip(x, -UNIT, UNIT);
      s = clip(y, -UNIT, UNIT);
   endtask

   task automatic pose_reset();
      for (int i = 0; i < 9; i++) pose_rot[i] = (i % 4 == 0) ? UNIT : 0;
      for (int i = 0; i < 3; i++) pose_pos[i] = 0;
      joints_done = 0;
   endtask

   // fold one joint into the pose; queue the pose rows after the last joint
   task automatic chain_joint(input joint_row_type j);
      longint st, ct, sa, ca, a, acc;
      longint tj [9];
      longint pj [3];
      longint nr [9];
      longint np [3];
      pose_row_type row;
      angle_sincos(j.theta, st, ct);
      angle_sincos(j.alpha, sa, ca);
      a = j.link_length;
      tj[0] = ct;
      tj[1] = clip(rnd30(-st * ca), -UNIT, UNIT);
      tj[2] = clip(rnd30(st * sa), -UNIT, UNIT);
      tj[3] = st;
      tj[4] = clip(rnd30(ct * ca), -UNIT, UNIT);
      tj[5] = clip(rnd30(-ct * sa), -UNIT, UNIT);
      tj[6] = 0;
      tj[7] = sa;
      tj[8] = ca;
      pj[0] = clip(rnd30(a * ct), I32_MIN, I32_MAX);
      pj[1] = clip(rnd30(a * st), I32_MIN, I32_MAX);
      pj[2] = j.link_offset;
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            acc = pose_rot[r*3] * tj[k] + pose_rot[r*3+1] * tj[3+k]
                + pose_rot[r*3+2] * tj[6+k];
            nr[r*3+k] = clip(rnd30(acc), -UNIT, UNIT);
         end
         acc = pose_rot[r*3] * pj[0] + pose_rot[r*3+1] * pj[1] + pose_rot[r*3+2] * pj[2];
         np[r] = clip(rnd30(acc) + pose_pos[r], I32_MIN, I32_MAX);
      end
      pose_rot = nr;
      pose_pos = np;
      joints_done++;
      if (joints_done < JOINTS) return;
      for (int r = 0; r < 3; r++) begin
         row.row_index = 2'(r);
         row.rot_col0 = 32'(pose_rot[r*3]);
         row.rot_col1 = 32'(pose_rot[r*3+1]);
         row.rot_col2 = 32'(pose_rot[r*3+2]);
         row.position = 32'(pose_pos[r]);
         row.last_row = (r == 2);
         pending_rows.push_back(row);
      end
      pose_reset();
   endtask

   // directed rows: zero chain gives a zero position; then extremes of every field
   joint_row_type directed [DIRECTED] = '{
      '{15'sd0, 15'sd0, 32'sd0, 32'sd0},
      '{15'sd0, 15'sd0, 32'sd0, 32'sd0},
      '{15'sd0, 15'sd0, 32'sd0, 32'sd0},
      '{15'sd0, 15'sd0, 32'sd0, 32'sd0},
      '{15'sd0, 15'sd0, 32'sd0, 32'sd0},
      '{15'sd0, 15'sd0, 32'sd0, 32'sd0},
      '{15'h4000, 15'sd16383, 32'h7FFFFFFF, 32'h80000000},
      '{15'sd16383, 15'h4000, 32'h80000000, 32'h7FFFFFFF},
      '{15'sd12868, -15'sd12868, 32'h7FFFFFFF, 32'h7FFFFFFF},
      '{-15'sd12868, 15'sd12868, 32'h80000000, 32'h80000000},
      '{15'sd6434, 15'sd6434, 32'h00010000, 32'h7FFFFFFF},
      '{15'sd0, 15'sd0, 32'h7FFFFFFF, 32'h7FFFFFFF},
      '{15'sd6433, -15'sd6435, 32'hFFFFFFFF, 32'h00000001}
   };
   // after the zero chain the row tags and the zero position are read off directly
   pose_row_type zero_chain_rows [3] = '{
      '{2'd0, 32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 1'b0},
      '{2'd1, 32'sd0, 32'sd1073741824, 32'sd0, 32'sd0, 1'b0},
      '{2'd2, 32'sd0, 32'sd0, 32'sd1073741824, 32'sd0, 1'b1}
   };

   // send one joint row, with a random idle burst before it unless quiet
   task automatic send_joint(input joint_row_type j, input bit quiet);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_theta <= j.theta;
      req_alpha <= j.alpha;
      req_link_length <= j.link_length;
      req_link_offset <= j.link_offset;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chain_joint(j);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_len();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      endcase
   endfunction

   function automatic joint_row_type rand_joint();
      joint_row_type j;
      j.theta = $urandom_range(0, 7) == 0 ? 15'($urandom)
                : 15'($signed($urandom_range(0, 25736)) - 12868);
      j.alpha = $urandom_range(0, 7) == 0 ? 15'($urandom)
                : 15'($signed($urandom_range(0, 25736)) - 12868);
      j.link_length = rand_len();
      j.link_offset = rand_len();
      return j;
   endfunction

   // receiver: random stall bursts, none in the quiet tail
   always @(negedge clock) begin
      if (reset || rsp_quiet) begin
         stall_left = 0;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare every rsp transaction with the oldest expected pose row
   always @(posedge clock) begin
      pose_row_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_row_index, rsp_rot_col0, rsp_rot_col1, rsp_rot_col2,
                 rsp_position, rsp_last_row};
         if (pending_rows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected pose row %p", got);
         end else begin
            want = pending_rows.pop_front();
            if (rows_seen < 3 &&
                (want.row_index != zero_chain_rows[rows_seen].row_index ||
                 want.position != zero_chain_rows[rows_seen].position ||
                 want.last_row != zero_chain_rows[rows_seen].last_row)) begin
               mismatches++;
               if (mismatches <= 10) $display("zero chain row: expected %p got %p",
                                              zero_chain_rows[rows_seen], want);
            end
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10) $display("pose row mismatch: expected %p got %p",
                                              want, got);
            end
         end
         rows_seen++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      joint_row_type j;
      pose_reset();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED; i++) begin
         send_joint(directed[i], 1'b0);
         // hold off until the zero-chain pose has fully drained
         if (i == 5) begin
            req_valid <= 1'b0;
            while (pending_rows.size() != 0) @(negedge clock);
         end
      end
      // mostly complete chains of random joints
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - QUIET_TAIL) rsp_quiet = 1'b1;
         j = rand_joint();
         send_joint(j, i >= RANDOM_ITEMS - QUIET_TAIL);
      end
      req_valid <= 1'b0;
      while (pending_rows.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (mismatches == 0 && pending_rows.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire
